// File: rtl/core/givens_linear_solver_macros.svh
// ----------------------------------------------------------------------------
// Givens linear solver assertion macros
// Shorthand for the concurrent checks used in the solver RTL.
// ----------------------------------------------------------------------------
`ifndef GIVENS_LINEAR_SOLVER_MACROS_SVH
`define GIVENS_LINEAR_SOLVER_MACROS_SVH

// Same-cycle implication, clocked on clock and held off during reset.
`define GLS_ASSERT_IMM(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gls check failed");

// Next-cycle implication, clocked on clock and held off during reset.
`define GLS_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gls check failed");

`endif

// File: rtl/core/gls_pkg.sv
// ----------------------------------------------------------------------------
// Givens linear solver package
// Sizes, sequencer states, unit status type and fixed-point helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package gls_pkg;

   localparam int MAX_UNKNOWNS = 8;
   localparam int ROW_W        = $clog2(MAX_UNKNOWNS);
   localparam int COL_W        = $clog2(MAX_UNKNOWNS + 2);
   localparam int DEPTH        = MAX_UNKNOWNS * (MAX_UNKNOWNS + 1);
   localparam int ADDR_W       = $clog2(DEPTH);
   localparam int SIZE_W       = 4;
   localparam int SIZE_RESET   = 4;
   localparam int STATE_W      = 30;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   typedef enum logic [STATE_W-1:0] {
      ST_LOAD    = 30'd1 << 0,
      ST_PIV_A   = 30'd1 << 1,
      ST_PIV_B   = 30'd1 << 2,
      ST_PIV_C   = 30'd1 << 3,
      ST_SQ1     = 30'd1 << 4,
      ST_SQ2     = 30'd1 << 5,
      ST_SQ3     = 30'd1 << 6,
      ST_SQW     = 30'd1 << 7,
      ST_DIVC    = 30'd1 << 8,
      ST_DIVS    = 30'd1 << 9,
      ST_ROT_X   = 30'd1 << 10,
      ST_ROT_Y   = 30'd1 << 11,
      ST_ROT_M1  = 30'd1 << 12,
      ST_ROT_M2  = 30'd1 << 13,
      ST_ROT_M3  = 30'd1 << 14,
      ST_ROT_M4  = 30'd1 << 15,
      ST_ROT_W   = 30'd1 << 16,
      ST_ROT_W2  = 30'd1 << 17,
      ST_NEXT    = 30'd1 << 18,
      ST_BS_INIT = 30'd1 << 19,
      ST_BS_ROW  = 30'd1 << 20,
      ST_BS_RD   = 30'd1 << 21,
      ST_BS_MUL  = 30'd1 << 22,
      ST_BS_ACC  = 30'd1 << 23,
      ST_BS_B    = 30'd1 << 24,
      ST_BS_D    = 30'd1 << 25,
      ST_BS_DIV  = 30'd1 << 26,
      ST_BS_WAIT = 30'd1 << 27,
      ST_BS_NEXT = 30'd1 << 28,
      ST_OUT     = 30'd1 << 29
   } state_type;

   function automatic logic [31:0] mag32(logic signed [31:0] v);
      return v[31] ? 32'(-v) : 32'(v);
   endfunction

   function automatic logic [63:0] mag64(logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   // Divide by 2^sh, rounding to nearest with ties away from zero.
   function automatic logic signed [63:0] rnd_shift(logic signed [63:0] v, int sh);
      logic [63:0] u;
      u = mag64(v);
      u = (u + (64'd1 << (sh - 1))) >> sh;
      return v[63] ? -$signed(u) : $signed(u);
   endfunction

   function automatic logic signed [31:0] sat32(logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/gls_mul.sv
// ----------------------------------------------------------------------------
// Givens linear solver multiplier
// Shared signed 33 by 33 multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module gls_mul (
   input  wire logic               clock,
   input  wire logic signed [32:0] op_a,
   input  wire logic signed [32:0] op_b,
   output logic signed [63:0]      prod
);
   logic signed [65:0] prod_in;
   logic signed [63:0] prod_ff;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in[63:0];
   end

   assign prod = prod_ff;
endmodule

`default_nettype wire

// File: rtl/core/gls_isqrt.sv
// ----------------------------------------------------------------------------
// Givens linear solver square root
// Digit-by-digit integer square root of a 64-bit value, one digit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gls_isqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] value,
   output gls_pkg::unit_stat_type stat,
   output logic [31:0]      root
);
   import gls_pkg::*;

   logic        busy_ff, busy_in, done_ff, done_in;
   logic [63:0] rem_ff, rem_in, res_ff, res_in, bit_ff, bit_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      trial   = res_ff + bit_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         rem_in  = value;
         res_in  = '0;
         bit_in  = 64'd1 << 62;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign root      = res_ff[31:0];
endmodule

`default_nettype wire

// File: rtl/core/gls_divider.sv
// ----------------------------------------------------------------------------
// Givens linear solver divider
// Restoring unsigned divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gls_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [31:0] divisor,
   output gls_pkg::unit_stat_type stat,
   output logic [63:0]      quotient
);
   import gls_pkg::*;

   logic        busy_ff, busy_in, done_ff, done_in;
   logic [63:0] num_ff, num_in, q_ff, q_in;
   logic [31:0] rem_ff, rem_in, den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      num_in  = num_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      trial   = {rem_ff, num_ff[63]};
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = '0;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 32'(trial - {1'b0, den_ff});
            q_in   = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            q_in   = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = q_ff;
endmodule

`default_nettype wire

// File: rtl/core/givens_linear_solver.sv
// ----------------------------------------------------------------------------
// Givens linear solver
// Loads an augmented n by n+1 Q16.16 system, triangularizes it with Givens
// rotations and back-substitutes, emitting solutions highest index first.
// ----------------------------------------------------------------------------
//  Channel   Dir  Fields
//  req_*     in   tdata = coefficient
//  rsp_*     out  tdata = solution_value, solution_index; tlast = is_last;
//                 tuser = singular
//  csr_*     in   data = system_size
//
//  Loading takes one item per cycle while req_tready is high, n*(n+1) items per run.
//  Each rotation pair uses the square root, two divisions and one shared multiplier.
//  Each back-substitution row accumulates its terms and divides by the diagonal.
//  Results leave from an output register; req_tready and csr_ready are low
//  while solving, and a csr write holds off req.
//  Reset clears control state only; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "givens_linear_solver_macros.svh"

module givens_linear_solver (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] coefficient
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [31:0] solution_value, [34:32] solution_index
   output logic             rsp_tlast,
   output logic             rsp_tuser,   // [0] singular
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_data     // [3:0] system_size
);
   import gls_pkg::*;

   state_type state_ff, state_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [ADDR_W-1:0] load_cnt_ff, load_cnt_in;
   logic [ROW_W-1:0]  i_ff, i_in, k_ff, k_in, br_ff, br_in, oj_ff, oj_in;
   logic [COL_W-1:0]  j_ff, j_in, t_ff, t_in;
   logic signed [31:0] a_ff, a_in, b_ff, b_in, x_ff, x_in, y_ff, y_in;
   logic signed [31:0] c_ff, c_in, s_ff, s_in;
   logic [31:0]        r_ff, r_in;
   logic signed [63:0] acc_ff, acc_in, top_ff, top_in, bot_ff, bot_in;
   logic signed [63:0] num_ff, num_in;
   logic               neg_ff, neg_in, sing_ff, sing_in;
   logic signed [31:0] xs_ff [MAX_UNKNOWNS];
   logic               xs_we;
   logic [ROW_W-1:0]   xs_waddr;
   logic signed [31:0] xs_wdata;

   logic               rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic               rsp_sing_ff, rsp_sing_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic [2:0]         rsp_idx_ff, rsp_idx_in;

   logic [31:0]        matrix_mem [DEPTH];
   logic [31:0]        mem_rdata_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
   logic [31:0]        mem_wdata;

   logic [COL_W-1:0]   n_eff, cols;
   logic [ADDR_W-1:0]  total;

   logic signed [32:0] mul_a, mul_b;
   logic signed [63:0] mul_p;
   logic               sqrt_start, div_start;
   logic [63:0]        sqrt_v, div_num, div_q, bs_m, bs_q;
   logic [31:0]        div_den, sqrt_res;
   unit_stat_type      sqrt_stat, div_stat;

   function automatic logic [ADDR_W-1:0] mat_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                                 logic [COL_W-1:0] w);
      return ADDR_W'(int'(r) * int'(w) + int'(c));
   endfunction

   gls_mul u_mul (.clock(clock), .op_a(mul_a), .op_b(mul_b), .prod(mul_p));

   gls_isqrt u_isqrt (
      .clock(clock), .reset(reset), .start(sqrt_start), .value(sqrt_v),
      .stat(sqrt_stat), .root(sqrt_res)
   );

   gls_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_num),
      .divisor(div_den), .stat(div_stat), .quotient(div_q)
   );

   always_comb begin
      if (size_ff == '0) begin
         n_eff = COL_W'(1);
      end else if (int'(size_ff) > MAX_UNKNOWNS) begin
         n_eff = COL_W'(MAX_UNKNOWNS);
      end else begin
         n_eff = COL_W'(size_ff);
      end
      cols  = n_eff + 1'b1;
      total = ADDR_W'(int'(n_eff) * int'(cols));
   end

   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      load_cnt_in  = load_cnt_ff;
      i_in = i_ff; k_in = k_ff; br_in = br_ff; oj_in = oj_ff;
      j_in = j_ff; t_in = t_ff;
      a_in = a_ff; b_in = b_ff; x_in = x_ff; y_in = y_ff;
      c_in = c_ff; s_in = s_ff; r_in = r_ff;
      acc_in = acc_ff; top_in = top_ff; bot_in = bot_ff; num_in = num_ff;
      neg_in = neg_ff; sing_in = sing_ff;
      xs_we = 1'b0; xs_waddr = '0; xs_wdata = '0;
      mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0; mem_raddr = '0;
      mul_a = '0; mul_b = '0;
      sqrt_start = 1'b0; sqrt_v = '0;
      div_start = 1'b0; div_num = '0; div_den = '0;
      bs_m = '0; bs_q = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_sing_in  = rsp_sing_ff;

      case (state_ff)
         ST_LOAD: begin
            if (req_tvalid && req_tready) begin
               mem_we    = 1'b1;
               mem_waddr = load_cnt_ff;
               mem_wdata = req_tdata;
               if (load_cnt_ff == total - 1'b1) begin
                  load_cnt_in = '0;
                  i_in        = '0;
                  k_in        = ROW_W'(1);
                  state_in    = (n_eff == COL_W'(1)) ? ST_BS_INIT : ST_PIV_A;
               end else begin
                  load_cnt_in = load_cnt_ff + 1'b1;
               end
            end
         end
         ST_PIV_A: begin
            mem_raddr = mat_addr(i_ff, COL_W'(i_ff), cols);
            state_in  = ST_PIV_B;
         end
         ST_PIV_B: begin
            a_in      = mem_rdata_ff;
            mem_raddr = mat_addr(k_ff, COL_W'(i_ff), cols);
            state_in  = ST_PIV_C;
         end
         ST_PIV_C: begin
            b_in = mem_rdata_ff;
            if (a_ff == '0 && mem_rdata_ff == '0) begin
               state_in = ST_NEXT;
            end else begin
               state_in = ST_SQ1;
            end
         end
         ST_SQ1: begin
            mul_a    = {1'b0, mag32(a_ff)};
            mul_b    = {1'b0, mag32(a_ff)};
            state_in = ST_SQ2;
         end
         ST_SQ2: begin
            acc_in   = mul_p;
            mul_a    = {1'b0, mag32(b_ff)};
            mul_b    = {1'b0, mag32(b_ff)};
            state_in = ST_SQ3;
         end
         ST_SQ3: begin
            sqrt_start = 1'b1;
            sqrt_v     = 64'(acc_ff + mul_p);
            state_in   = ST_SQW;
         end
         ST_SQW: begin
            if (sqrt_stat.done) begin
               r_in      = sqrt_res;
               div_start = 1'b1;
               div_num   = 64'(mag32(a_ff)) << 30;
               div_den   = sqrt_res;
               state_in  = ST_DIVC;
            end
         end
         ST_DIVC: begin
            if (div_stat.done) begin
               c_in      = a_ff[31] ? -$signed(div_q[31:0]) : $signed(div_q[31:0]);
               div_start = 1'b1;
               div_num   = 64'(mag32(b_ff)) << 30;
               div_den   = r_ff;
               state_in  = ST_DIVS;
            end
         end
         ST_DIVS: begin
            if (div_stat.done) begin
               s_in     = b_ff[31] ? -$signed(div_q[31:0]) : $signed(div_q[31:0]);
               j_in     = '0;
               state_in = ST_ROT_X;
            end
         end
         ST_ROT_X: begin
            mem_raddr = mat_addr(i_ff, j_ff, cols);
            state_in  = ST_ROT_Y;
         end
         ST_ROT_Y: begin
            x_in      = mem_rdata_ff;
            mem_raddr = mat_addr(k_ff, j_ff, cols);
            state_in  = ST_ROT_M1;
         end
         ST_ROT_M1: begin
            y_in     = mem_rdata_ff;
            mul_a    = {c_ff[31], c_ff};
            mul_b    = {x_ff[31], x_ff};
            state_in = ST_ROT_M2;
         end
         ST_ROT_M2: begin
            acc_in   = mul_p;
            mul_a    = {s_ff[31], s_ff};
            mul_b    = {y_ff[31], y_ff};
            state_in = ST_ROT_M3;
         end
         ST_ROT_M3: begin
            top_in   = acc_ff + mul_p;
            mul_a    = {c_ff[31], c_ff};
            mul_b    = {y_ff[31], y_ff};
            state_in = ST_ROT_M4;
         end
         ST_ROT_M4: begin
            mem_we    = 1'b1;
            mem_waddr = mat_addr(i_ff, j_ff, cols);
            mem_wdata = sat32(rnd_shift(top_ff, 30));
            acc_in    = mul_p;
            mul_a     = {s_ff[31], s_ff};
            mul_b     = {x_ff[31], x_ff};
            state_in  = ST_ROT_W;
         end
         ST_ROT_W: begin
            bot_in   = acc_ff - mul_p;
            state_in = ST_ROT_W2;
         end
         ST_ROT_W2: begin
            mem_we    = 1'b1;
            mem_waddr = mat_addr(k_ff, j_ff, cols);
            mem_wdata = sat32(rnd_shift(bot_ff, 30));
            if (j_ff == n_eff) begin
               state_in = ST_NEXT;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = ST_ROT_X;
            end
         end
         ST_NEXT: begin
            if (COL_W'(k_ff) == n_eff - 1'b1) begin
               if (COL_W'(i_ff) == n_eff - COL_W'(2)) begin
                  state_in = ST_BS_INIT;
               end else begin
                  i_in     = i_ff + 1'b1;
                  k_in     = i_ff + ROW_W'(2);
                  state_in = ST_PIV_A;
               end
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_PIV_A;
            end
         end
         ST_BS_INIT: begin
            br_in    = ROW_W'(n_eff - 1'b1);
            sing_in  = 1'b0;
            state_in = ST_BS_ROW;
         end
         ST_BS_ROW: begin
            acc_in = '0;
            t_in   = COL_W'(br_ff) + 1'b1;
            if (COL_W'(br_ff) + 1'b1 == n_eff) begin
               state_in = ST_BS_B;
            end else begin
               state_in = ST_BS_RD;
            end
         end
         ST_BS_RD: begin
            mem_raddr = mat_addr(br_ff, t_ff, cols);
            state_in  = ST_BS_MUL;
         end
         ST_BS_MUL: begin
            mul_a    = {mem_rdata_ff[31], mem_rdata_ff};
            mul_b    = {xs_ff[t_ff[ROW_W-1:0]][31], xs_ff[t_ff[ROW_W-1:0]]};
            state_in = ST_BS_ACC;
         end
         ST_BS_ACC: begin
            acc_in = acc_ff + rnd_shift(mul_p, 16);
            t_in   = t_ff + 1'b1;
            if (t_ff + 1'b1 == n_eff) begin
               state_in = ST_BS_B;
            end else begin
               state_in = ST_BS_RD;
            end
         end
         ST_BS_B: begin
            mem_raddr = mat_addr(br_ff, n_eff, cols);
            state_in  = ST_BS_D;
         end
         ST_BS_D: begin
            num_in    = {{32{mem_rdata_ff[31]}}, mem_rdata_ff} - acc_ff;
            mem_raddr = mat_addr(br_ff, COL_W'(br_ff), cols);
            state_in  = ST_BS_DIV;
         end
         ST_BS_DIV: begin
            if (mem_rdata_ff == '0) begin
               sing_in  = 1'b1;
               xs_we    = 1'b1;
               xs_waddr = br_ff;
               xs_wdata = '0;
               state_in = ST_BS_NEXT;
            end else begin
               bs_m = mag64(num_ff);
               if (bs_m > (64'd1 << 47)) begin
                  bs_m = 64'd1 << 47;
               end
               div_start = 1'b1;
               div_num   = bs_m << 16;
               div_den   = mag32(mem_rdata_ff);
               neg_in    = num_ff[63] ^ mem_rdata_ff[31];
               state_in  = ST_BS_WAIT;
            end
         end
         ST_BS_WAIT: begin
            if (div_stat.done) begin
               bs_q = div_q;
               if (bs_q > (64'd1 << 32)) begin
                  bs_q = 64'd1 << 32;
               end
               xs_we    = 1'b1;
               xs_waddr = br_ff;
               xs_wdata = sat32(neg_ff ? -$signed(bs_q) : $signed(bs_q));
               state_in = ST_BS_NEXT;
            end
         end
         ST_BS_NEXT: begin
            if (br_ff == '0) begin
               oj_in    = ROW_W'(n_eff - 1'b1);
               state_in = ST_OUT;
            end else begin
               br_in    = br_ff - 1'b1;
               state_in = ST_BS_ROW;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = xs_ff[oj_ff];
               rsp_idx_in   = 3'(oj_ff);
               rsp_last_in  = (oj_ff == '0);
               rsp_sing_in  = sing_ff;
               if (oj_ff == '0) begin
                  state_in = ST_LOAD;
               end else begin
                  oj_in = oj_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      if (csr_valid && csr_ready) begin
         size_in     = csr_data;
         load_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         size_ff      <= SIZE_W'(SIZE_RESET);
         load_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         load_cnt_ff  <= load_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff <= i_in; k_ff <= k_in; br_ff <= br_in; oj_ff <= oj_in;
      j_ff <= j_in; t_ff <= t_in;
      a_ff <= a_in; b_ff <= b_in; x_ff <= x_in; y_ff <= y_in;
      c_ff <= c_in; s_ff <= s_in; r_ff <= r_in;
      acc_ff <= acc_in; top_ff <= top_in; bot_ff <= bot_in; num_ff <= num_in;
      neg_ff <= neg_in; sing_ff <= sing_in;
      rsp_value_ff <= rsp_value_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_sing_ff  <= rsp_sing_in;
      if (xs_we) begin
         xs_ff[xs_waddr] <= xs_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         matrix_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= matrix_mem[mem_raddr];
   end

   assign req_tready = (state_ff == ST_LOAD) && !csr_valid;
   assign csr_ready  = (state_ff == ST_LOAD);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_idx_ff, rsp_value_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_sing_ff;

   `GLS_ASSERT_IMM(a_last_index, rsp_tvalid && rsp_tlast, rsp_tdata[34:32] == 3'd0)
   `GLS_ASSERT_IMM(a_wr_range, mem_we, mem_waddr < ADDR_W'(DEPTH))
   `GLS_ASSERT_IMM(a_units_excl, div_stat.busy, !sqrt_stat.busy)
   `GLS_ASSERT_NXT(a_load_wrap, req_tvalid && req_tready && load_cnt_ff == total - 1'b1,
                   load_cnt_ff == '0)
endmodule

`default_nettype wire
